// ===== rtl/core/mmss_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mmss_pkg
// Shared types, constants and helpers for the exhaustive min-makespan search.
// ----------------------------------------------------------------------------
package mmss_pkg;

  // Fixed payload widths of the ports
  localparam int IDX_W       = 3;
  localparam int IN_WEIGHT_W = 16;
  localparam int OUT_W       = 19;
  localparam int CFG_W       = 4;
  localparam int CFG_IDX_W   = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_MACHINES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_JOBS     = 1'b1;

  // Register reset values
  localparam logic [CFG_W-1:0] NUM_MACHINES_RST = 4'd1;
  localparam logic [CFG_W-1:0] NUM_JOBS_RST     = 4'd1;

  // Default sizes
  localparam int DEF_MAX_JOBS     = 8;
  localparam int DEF_MAX_MACHINES = 8;
  localparam int DEF_WEIGHT_BITS  = 16;

  // Status from the search sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } seq_status_t;

  // Clamp a count register to 1..limit and return the last zero-based index
  function automatic int clamp_last(input logic [CFG_W-1:0] v, input int limit);
    int c;
    c = int'(v);
    if (c == 0) c = 1;
    if (c > limit) c = limit;
    return c - 1;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/mmss_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mmss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mmss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/mmss_alu.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mmss_alu
// Shared load adder: adds a weight to a machine load, or takes it back off.
// ----------------------------------------------------------------------------
module mmss_alu #(
  parameter int LOAD_W      = 19,
  parameter int WEIGHT_BITS = 16
) (
  input  wire logic [LOAD_W-1:0]      load_in,
  input  wire logic [WEIGHT_BITS-1:0] weight,
  input  wire logic                   sub,
  output logic      [LOAD_W-1:0]      load_out
);

  logic [LOAD_W-1:0] weight_ext;

  // Widen the weight to load width
  assign weight_ext = LOAD_W'(weight);

  // Add on descent, subtract on backtrack
  always_comb begin
    if (sub) begin
      load_out = load_in - weight_ext;
    end else begin
      load_out = load_in + weight_ext;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/mmss_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mmss_seq
// Depth-first search sequencer: walks job-to-machine assignments, keeps the
// machine loads and per-level running maximum, and prunes hopeless branches.
// ----------------------------------------------------------------------------
module mmss_seq #(
  parameter int MAX_JOBS     = mmss_pkg::DEF_MAX_JOBS,
  parameter int MAX_MACHINES = mmss_pkg::DEF_MAX_MACHINES,
  parameter int WEIGHT_BITS  = mmss_pkg::DEF_WEIGHT_BITS,
  localparam int LVL_W  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1,
  localparam int DIG_W  = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1,
  localparam int LOAD_W = WEIGHT_BITS + $clog2(MAX_JOBS),
  localparam int DEPTH  = MAX_JOBS * MAX_MACHINES,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [LVL_W-1:0]       jobs_last,
  input  wire logic [DIG_W-1:0]       mach_last,
  output logic                        rd_en,
  output logic      [ADDR_W-1:0]      rd_addr,
  input  wire logic [WEIGHT_BITS-1:0] rd_data,
  input  wire logic                   ack,
  output mmss_pkg::seq_status_t       status,
  output logic      [LOAD_W-1:0]      best
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FETCH = 6'b000010,
    S_ADD   = 6'b000100,
    S_CMP   = 6'b001000,
    S_BACK  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state;

  logic [LVL_W-1:0]       level;
  logic [LVL_W-1:0]       level_up;
  logic [LVL_W-1:0]       jobs_last_q;
  logic [DIG_W-1:0]       mach_last_q;
  logic [DIG_W-1:0]       digit [MAX_JOBS];
  logic [LOAD_W-1:0]      loads [MAX_MACHINES];
  logic [LOAD_W-1:0]      max_stk [MAX_JOBS];
  logic [WEIGHT_BITS-1:0] w_stk [MAX_JOBS];
  logic [WEIGHT_BITS-1:0] w_q;
  logic [LOAD_W-1:0]      sum_q;
  logic                   best_valid;

  logic [DIG_W-1:0]       cur_dig;
  logic [LOAD_W-1:0]      cur_max;
  logic [LOAD_W-1:0]      cand;
  logic [LOAD_W-1:0]      alu_y;
  logic [WEIGHT_BITS-1:0] alu_b;
  logic                   alu_sub;
  logic                   pruned;
  logic                   last_dig;
  logic                   at_leaf;
  logic                   at_root;

  // Current node of the walk
  assign cur_dig  = digit[level];
  assign cur_max  = max_stk[level];
  assign level_up = level + 1'b1;
  assign last_dig = (cur_dig == mach_last_q);
  assign at_leaf  = (level == jobs_last_q);
  assign at_root  = (level == '0);

  // Candidate makespan and the cut against the best so far
  assign cand   = (sum_q > cur_max) ? sum_q : cur_max;
  assign pruned = best_valid && (cand >= best);

  // Weight fetch for the current node
  assign rd_en   = (state == S_FETCH);
  assign rd_addr = ADDR_W'(level) * ADDR_W'(MAX_MACHINES) + ADDR_W'(cur_dig);

  // Shared adder: add on try, subtract on backtrack
  assign alu_sub = (state == S_BACK);
  assign alu_b   = alu_sub ? w_stk[level] : rd_data;

  mmss_alu #(
    .LOAD_W      (LOAD_W),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_alu (
    .load_in  (loads[cur_dig]),
    .weight   (alu_b),
    .sub      (alu_sub),
    .load_out (alu_y)
  );

  assign status.busy = (state != S_IDLE);
  assign status.done = (state == S_DONE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      best_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            level       <= '0;
            digit[0]    <= '0;
            max_stk[0]  <= '0;
            best_valid  <= 1'b0;
            jobs_last_q <= jobs_last;
            mach_last_q <= mach_last;
            for (int m = 0; m < MAX_MACHINES; m++) begin
              loads[m] <= '0;
            end
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          state <= S_ADD;
        end
        S_ADD: begin
          sum_q <= alu_y;
          w_q   <= rd_data;
          state <= S_CMP;
        end
        S_CMP: begin
          if (!pruned && !at_leaf) begin
            // Descend: commit the load and open the next job
            loads[cur_dig]    <= sum_q;
            w_stk[level]      <= w_q;
            max_stk[level_up] <= cand;
            digit[level_up]   <= '0;
            level             <= level_up;
            state             <= S_FETCH;
          end else begin
            if (!pruned) begin
              best       <= cand;
              best_valid <= 1'b1;
            end
            // Advance to the next machine or climb back
            if (!last_dig) begin
              digit[level] <= cur_dig + 1'b1;
              state        <= S_FETCH;
            end else if (at_root) begin
              state <= S_DONE;
            end else begin
              level <= level - 1'b1;
              state <= S_BACK;
            end
          end
        end
        S_BACK: begin
          // Drop the weight of this level's job from its machine
          loads[cur_dig] <= alu_y;
          if (!last_dig) begin
            digit[level] <= cur_dig + 1'b1;
            state        <= S_FETCH;
          end else if (at_root) begin
            state <= S_DONE;
          end else begin
            level <= level - 1'b1;
            state <= S_BACK;
          end
        end
        S_DONE: begin
          if (ack) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/exhaustive_min_makespan_search_unit.sv =====
`default_nettype none
// A weight write word is stored in the table. A start word runs a depth-first
// search: each tried node passes the fetch, add and compare states, each
// backtrack the back state, and branches that cannot beat the best are cut.
// Throughput: one word per cycle for writes; in_stall is high during a search.
// The single adder and the one table read port set the search time.
// Reset: synchronous; clears sequencer and output valid, config counts to 1.
// ----------------------------------------------------------------------------
// exhaustive_min_makespan_search_unit
// Loads a job-by-machine weight table and, on a start word, returns the
// smallest makespan over all assignments of jobs to machines.
// ----------------------------------------------------------------------------
module exhaustive_min_makespan_search_unit #(
  parameter int MAX_JOBS     = mmss_pkg::DEF_MAX_JOBS,
  parameter int MAX_MACHINES = mmss_pkg::DEF_MAX_MACHINES,
  parameter int WEIGHT_BITS  = mmss_pkg::DEF_WEIGHT_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [mmss_pkg::IDX_W-1:0]          job_index,
  input  wire logic [mmss_pkg::IDX_W-1:0]          machine_index,
  input  wire logic [mmss_pkg::IN_WEIGHT_W-1:0]    job_weight,
  input  wire logic                                start_search,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic      [mmss_pkg::OUT_W-1:0]          best_makespan,
  input  wire logic                                cfg_write,
  input  wire logic [mmss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [mmss_pkg::CFG_W-1:0]          cfg_data
);

  localparam int LVL_W  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int DIG_W  = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
  localparam int LOAD_W = WEIGHT_BITS + $clog2(MAX_JOBS);
  localparam int DEPTH  = MAX_JOBS * MAX_MACHINES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [mmss_pkg::CFG_W-1:0] num_machines;
  logic [mmss_pkg::CFG_W-1:0] num_jobs;

  mmss_pkg::seq_status_t status;

  logic                   in_take;
  logic                   start;
  logic                   wr_en;
  logic                   in_range;
  logic [ADDR_W-1:0]      wr_addr;
  logic [WEIGHT_BITS-1:0] wr_data;
  logic                   rd_en;
  logic [ADDR_W-1:0]      rd_addr;
  logic [WEIGHT_BITS-1:0] rd_data;
  logic [LVL_W-1:0]       jobs_last;
  logic [DIG_W-1:0]       mach_last;
  logic                   ack;
  logic [LOAD_W-1:0]      best;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_machines <= mmss_pkg::NUM_MACHINES_RST;
      num_jobs     <= mmss_pkg::NUM_JOBS_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mmss_pkg::REG_NUM_MACHINES: num_machines <= cfg_data;
        mmss_pkg::REG_NUM_JOBS:     num_jobs     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input handshake: hold off while a search runs
  assign in_stall = status.busy;
  assign in_take  = in_valid && !in_stall;
  assign start    = in_take && start_search;

  // Table write; drop words whose indexes fall outside the table
  assign in_range = (int'(job_index) < MAX_JOBS) && (int'(machine_index) < MAX_MACHINES);
  assign wr_en    = in_take && !start_search && in_range;
  assign wr_addr  = ADDR_W'(job_index) * ADDR_W'(MAX_MACHINES) + ADDR_W'(machine_index);
  assign wr_data  = WEIGHT_BITS'(job_weight);

  mmss_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Clamp the counts to 1..limit, passed on as last indexes
  assign jobs_last = LVL_W'(mmss_pkg::clamp_last(num_jobs, MAX_JOBS));
  assign mach_last = DIG_W'(mmss_pkg::clamp_last(num_machines, MAX_MACHINES));

  mmss_seq #(
    .MAX_JOBS     (MAX_JOBS),
    .MAX_MACHINES (MAX_MACHINES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .jobs_last (jobs_last),
    .mach_last (mach_last),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .ack       (ack),
    .status    (status),
    .best      (best)
  );

  // Output register: load the result once the slot is free
  assign ack = status.done && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ack) begin
      out_valid     <= 1'b1;
      best_makespan <= mmss_pkg::OUT_W'(best);
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire
